// ----- rtl/core/rgb_to_hsv_pixel_assert.svh -----
// Assertion macros for the RGB to HSV pixel converter.
// Expects clk_i and rst_ni in the scope of the module that includes it.
`ifndef RGB_TO_HSV_PIXEL_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_ASSERT_SVH

// same-cycle implication
`define HSV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rgb_to_hsv_pixel: assertion failed");

// next-cycle implication
`define HSV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rgb_to_hsv_pixel: assertion failed");

`endif

// ----- rtl/core/hsv_pkg.sv -----
// Shared types and constants for the RGB to HSV pixel converter.
// No dependencies.
package hsv_pkg;

  localparam int unsigned HSV_CELLS   = 8;
  localparam int unsigned HSV_LATENCY = HSV_CELLS + 2;

  localparam logic [7:0] HUE_SIXTH  = 8'd43;
  localparam logic [7:0] FULL_SCALE = 8'd255;
  localparam logic [7:0] BASE_RED   = 8'd0;
  localparam logic [7:0] BASE_GREEN = 8'd85;
  localparam logic [7:0] BASE_BLUE  = 8'd171;

  // one word in flight through the divider cells
  typedef struct packed {
    logic [7:0] mx;
    logic [7:0] dv;
    logic [7:0] s_rem;
    logic [7:0] s_low;
    logic [7:0] s_quo;
    logic [7:0] h_rem;
    logic [7:0] h_low;
    logic [7:0] h_quo;
    logic       neg;
    logic [7:0] base;
    logic [7:0] pad;
    logic       last;
  } hsv_word_t;

endpackage

// ----- rtl/core/hsv_prep.sv -----
// Front stage: channel max/min, hue sector, and both dividends.
// Depends on hsv_pkg.
module hsv_prep import hsv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic [7:0] pad_i,
  input  logic       last_i,
  output logic       vld_o,
  output hsv_word_t  word_o
);

  logic [7:0]  mx, mn, delta, absd, base;
  logic [8:0]  diff;
  logic [15:0] s_num, h_num;
  hsv_word_t   word_d, word_q;
  logic        vld_q;

  always_comb begin
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    delta = mx - mn;
    if (mx == red_i) begin
      base = BASE_RED;
      diff = {1'b0, green_i} - {1'b0, blue_i};
    end else if (mx == green_i) begin
      base = BASE_GREEN;
      diff = {1'b0, blue_i} - {1'b0, red_i};
    end else begin
      base = BASE_BLUE;
      diff = {1'b0, red_i} - {1'b0, green_i};
    end
    absd  = diff[8] ? 8'(-diff) : diff[7:0];
    s_num = {8'd0, FULL_SCALE} * {8'd0, delta};
    h_num = {8'd0, HUE_SIXTH} * {8'd0, absd};
    word_d.mx    = mx;
    word_d.dv    = delta;
    word_d.s_rem = s_num[15:8];
    word_d.s_low = s_num[7:0];
    word_d.s_quo = '0;
    word_d.h_rem = h_num[15:8];
    word_d.h_low = h_num[7:0];
    word_d.h_quo = '0;
    word_d.neg   = diff[8];
    word_d.base  = base;
    word_d.pad   = pad_i;
    word_d.last  = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign vld_o  = vld_q;
  assign word_o = word_q;

endmodule

// ----- rtl/core/hsv_cell.sv -----
// Divider cell: one restoring step for saturation and for hue quotients.
// Depends on hsv_pkg.
module hsv_cell import hsv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      vld_i,
  input  hsv_word_t word_i,
  output logic      vld_o,
  output hsv_word_t word_o
);

  logic [8:0] s_t, h_t, s_r, h_r;
  logic       s_ge, h_ge;
  hsv_word_t  word_d, word_q;
  logic       vld_q;

  always_comb begin
    s_t  = {word_i.s_rem, word_i.s_low[7]};
    h_t  = {word_i.h_rem, word_i.h_low[7]};
    s_ge = s_t >= {1'b0, word_i.mx};
    h_ge = h_t >= {1'b0, word_i.dv};
    s_r  = s_ge ? s_t - {1'b0, word_i.mx} : s_t;
    h_r  = h_ge ? h_t - {1'b0, word_i.dv} : h_t;
    word_d       = word_i;
    word_d.s_rem = s_r[7:0];
    word_d.h_rem = h_r[7:0];
    word_d.s_low = {word_i.s_low[6:0], 1'b0};
    word_d.h_low = {word_i.h_low[6:0], 1'b0};
    word_d.s_quo = {word_i.s_quo[6:0], s_ge};
    word_d.h_quo = {word_i.h_quo[6:0], h_ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign vld_o  = vld_q;
  assign word_o = word_q;

endmodule

// ----- rtl/core/rgb_to_hsv_pixel.sv -----
// RGB to HSV pixel converter: one pixel accepted every cycle (busy is never raised).
// A pixel passes through the front stage, eight divider cells, and the output stage.
// Reset clears all valid flags; words in flight are dropped.
// Results are shown for one cycle on valid_o; the receiver cannot stall.
// Depends on hsv_pkg, hsv_prep, hsv_cell, rgb_to_hsv_pixel_assert.svh.
`include "rgb_to_hsv_pixel_assert.svh"
module rgb_to_hsv_pixel import hsv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic [7:0] pad_in_i,
  input  logic       last_pixel_i,
  output logic       valid_o,
  output logic [7:0] hue_o,
  output logic [7:0] saturation_o,
  output logic [7:0] value_o,
  output logic [7:0] pad_out_o,
  output logic       last_out_o
);

  hsv_word_t  chain_w [HSV_CELLS+1];
  logic       chain_v [HSV_CELLS+1];
  hsv_word_t  fin;
  logic [7:0] hq, hue_d, sat_d, val_d;
  logic       valid_q;
  logic [7:0] hue_q, sat_q, val_q, pad_q;
  logic       last_q;

  assign busy = 1'b0;

  hsv_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .pad_i   (pad_in_i),
    .last_i  (last_pixel_i),
    .vld_o   (chain_v[0]),
    .word_o  (chain_w[0])
  );

  for (genvar i = 0; i < HSV_CELLS; i++) begin : g_cell
    hsv_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (chain_v[i]),
      .word_i (chain_w[i]),
      .vld_o  (chain_v[i+1]),
      .word_o (chain_w[i+1])
    );
  end

  always_comb begin
    fin   = chain_w[HSV_CELLS];
    hq    = fin.neg ? 8'(-fin.h_quo) : fin.h_quo;
    hue_d = fin.base + hq;
    sat_d = fin.s_quo;
    val_d = fin.mx;
    if (fin.mx == 8'd0) begin
      hue_d = '0;
      sat_d = '0;
      val_d = '0;
    end else if (fin.s_quo == 8'd0) begin
      hue_d = '0;
      sat_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= chain_v[HSV_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q  <= hue_d;
    sat_q  <= sat_d;
    val_q  <= val_d;
    pad_q  <= fin.pad;
    last_q <= fin.last;
  end

  assign valid_o      = valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign value_o      = val_q;
  assign pad_out_o    = pad_q;
  assign last_out_o   = last_q;

  `HSV_ASSERT_NOW(a_black_zero, valid_o && value_o == 8'd0, hue_o == 8'd0 && saturation_o == 8'd0)
  `HSV_ASSERT_NOW(a_grey_hue, valid_o && saturation_o == 8'd0, hue_o == 8'd0)
  `HSV_ASSERT_NOW(a_latency, $past(rst_ni, HSV_LATENCY) && $past(start, HSV_LATENCY), valid_o)
  `HSV_ASSERT_NEXT(a_final_cell, chain_v[HSV_CELLS], valid_o)

endmodule

// ----- dv/testbench.sv -----
// Testbench for rgb_to_hsv_pixel: drives RGB pixels with random sender gaps and
// checks every strobed HSV word against an in-order queue of predicted results.
// Depends on hsv_pkg and the rgb_to_hsv_pixel RTL.
module testbench;
  import hsv_pkg::HSV_LATENCY;

  localparam int SIXTH_STEP  = 43;
  localparam int RED_BASE    = 0;
  localparam int GREEN_BASE  = 85;
  localparam int BLUE_BASE   = 171;
  localparam int SAT_SCALE   = 255;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] value;
    logic [7:0] pad;
    logic       last;
  } hsv_pixel_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [7:0] red_i = 8'd0;
  logic [7:0] green_i = 8'd0;
  logic [7:0] blue_i = 8'd0;
  logic [7:0] pad_in_i = 8'd0;
  logic       last_pixel_i = 1'b0;
  logic       valid_o;
  logic [7:0] hue_o;
  logic [7:0] saturation_o;
  logic [7:0] value_o;
  logic [7:0] pad_out_o;
  logic       last_out_o;

  hsv_pixel_t pending_hsv_q[$];
  int         mismatch_count = 0;
  int         cycle_count = 0;

  rgb_to_hsv_pixel dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .pad_in_i    (pad_in_i),
    .last_pixel_i(last_pixel_i),
    .valid_o     (valid_o),
    .hue_o       (hue_o),
    .saturation_o(saturation_o),
    .value_o     (value_o),
    .pad_out_o   (pad_out_o),
    .last_out_o  (last_out_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rgb_to_hsv_pixel verification failed");
      $finish;
    end
  end

  function automatic hsv_pixel_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                               logic [7:0] pad, logic last);
    hsv_pixel_t px;
    int         mx;
    int         mn;
    int         span;
    int         sat;
    int         base;
    int         diff;
    px = '0;
    px.pad = pad;
    px.last = last;
    mx = int'(r);
    if (int'(g) > mx) mx = int'(g);
    if (int'(b) > mx) mx = int'(b);
    mn = int'(r);
    if (int'(g) < mn) mn = int'(g);
    if (int'(b) < mn) mn = int'(b);
    span = mx - mn;
    if (mx != 0) begin
      px.value = 8'(mx);
      sat = (SAT_SCALE * span) / mx;
      if (sat != 0) begin
        px.saturation = 8'(sat);
        if (mx == int'(r)) begin
          base = RED_BASE;
          diff = int'(g) - int'(b);
        end else if (mx == int'(g)) begin
          base = GREEN_BASE;
          diff = int'(b) - int'(r);
        end else begin
          base = BLUE_BASE;
          diff = int'(r) - int'(g);
        end
        px.hue = 8'(base + (SIXTH_STEP * diff) / span);
      end
    end
    return px;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    hsv_pixel_t want;
    if (rst_ni && valid_o) begin
      if (pending_hsv_q.size() == 0) begin
        report_mismatch("unexpected word, hue", int'(hue_o), 0);
      end else begin
        want = pending_hsv_q.pop_front();
        if (hue_o !== want.hue) report_mismatch("hue", int'(hue_o), int'(want.hue));
        if (saturation_o !== want.saturation)
          report_mismatch("saturation", int'(saturation_o), int'(want.saturation));
        if (value_o !== want.value)
          report_mismatch("value", int'(value_o), int'(want.value));
        if (pad_out_o !== want.pad)
          report_mismatch("pad_out", int'(pad_out_o), int'(want.pad));
        if (last_out_o !== want.last)
          report_mismatch("last_out", int'(last_out_o), int'(want.last));
      end
    end
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic [7:0] pad, logic last);
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    pad_in_i <= pad;
    last_pixel_i <= last;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_hsv_q.push_back(convert_pixel(r, g, b, pad, last));
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_hsv_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(int idle_pct);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    int         v;
    int         kind;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    kind = $urandom_range(9);
    case (kind)
      6: begin
        v = $urandom_range(1, 254);
        r = 8'($urandom_range(v - 1, v + 1));
        g = 8'($urandom_range(v - 1, v + 1));
        b = 8'($urandom_range(v - 1, v + 1));
      end
      7: begin
        case ($urandom_range(2))
          0: g = r;
          1: b = g;
          default: b = r;
        endcase
      end
      8: begin
        r = 8'($urandom_range(0, 3));
        g = 8'($urandom_range(0, 3));
        b = 8'($urandom_range(0, 3));
      end
      9: begin
        r = 8'($urandom_range(250, 255));
        g = 8'($urandom_range(250, 255));
        b = 8'($urandom_range(250, 255));
      end
      default: ;
    endcase
    send_pixel(r, g, b, 8'($urandom), 1'($urandom_range(1)));
  endtask

  task automatic test_special_pixels();
    send_pixel(8'd0, 8'd0, 8'd0, 8'hFF, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 8'h00, 1'b0);
    send_pixel(8'd128, 8'd128, 8'd128, 8'hAA, 1'b1);
    send_pixel(8'd1, 8'd1, 8'd1, 8'h55, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 8'h01, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 8'h80, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd255, 8'h7F, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd10, 8'hFE, 1'b0);
    send_pixel(8'd10, 8'd255, 8'd0, 8'h12, 1'b1);
    send_pixel(8'd0, 8'd10, 8'd255, 8'h34, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd0, 8'h56, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd255, 8'h78, 1'b1);
    send_pixel(8'd255, 8'd0, 8'd255, 8'h9A, 1'b0);
    send_pixel(8'd1, 8'd0, 8'd0, 8'hBC, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd1, 8'hDE, 1'b1);
    send_pixel(8'd2, 8'd1, 8'd1, 8'hF0, 1'b0);
    send_pixel(8'd255, 8'd254, 8'd0, 8'h0F, 1'b0);
    send_pixel(8'd200, 8'd100, 8'd199, 8'h3C, 1'b1);
    send_pixel(8'd0, 8'd1, 8'd0, 8'hC3, 1'b0);
    wait_for_results();
  endtask

  task automatic test_sparse_idle();
    repeat (380) send_random(7);
  endtask

  task automatic test_heavy_idle();
    repeat (180) send_random(74);
    wait_for_results();
    repeat (190) send_random(74);
  endtask

  task automatic test_back_to_back();
    repeat (380) send_random(0);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_pixels();
    test_sparse_idle();
    test_heavy_idle();
    test_back_to_back();
    wait_for_results();
    repeat (HSV_LATENCY + 4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("rgb_to_hsv_pixel verification clean");
    end else begin
      $display("rgb_to_hsv_pixel verification failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/hsv_pkg.sv
rtl/core/hsv_prep.sv
rtl/core/hsv_cell.sv
rtl/core/rgb_to_hsv_pixel.sv
dv/testbench.sv
